### rtl/connect_retry_backoff_gate_defines.svh
// assertion helpers for the connect retry backoff gate
`ifndef CONNECT_RETRY_BACKOFF_GATE_DEFINES_SVH
`define CONNECT_RETRY_BACKOFF_GATE_DEFINES_SVH

// same-cycle implication, off while reset is held
`define CRBG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define CRBG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/crbg_pkg.sv
package crbg_pkg;

    localparam int TIME_BITS_DEF  = 56;
    localparam int COUNT_BITS_DEF = 7;

    // event kinds
    localparam logic [1:0] ACT_ATTEMPT = 2'd0;
    localparam logic [1:0] ACT_OUTCOME = 2'd1;
    localparam logic [1:0] ACT_CLOSE   = 2'd2;
    localparam logic [1:0] ACT_END_REQ = 2'd3;

    // configuration register indexes
    localparam int         CFG_IDX_BITS  = 2;
    localparam int         CFG_DATA_BITS = 24;
    localparam logic [1:0] CFG_INITIAL   = 2'd0;
    localparam logic [1:0] CFG_MAX_EXP   = 2'd1;
    localparam logic [1:0] CFG_LOCK_HOLD = 2'd2;
    localparam logic [1:0] CFG_WINDOW    = 2'd3;

    localparam logic [15:0] INITIAL_RST   = 16'd3000;
    localparam logic [3:0]  MAX_EXP_RST   = 4'd10;
    localparam logic [15:0] LOCK_HOLD_RST = 16'd3000;
    localparam logic [23:0] WINDOW_RST    = 24'd4096000;

    typedef struct packed {
        logic [15:0] backoff_initial_ms;
        logic [3:0]  backoff_max_exponent;
        logic [15:0] lock_hold_ms;
        logic [23:0] suppression_window_ms;
    } t_cfg;

    typedef struct packed {
        logic may_connect;
        logic lock_taken;
        logic link_up;
    } t_flags;

endpackage

### rtl/crbg_core.sv
module crbg_core #(
    parameter int TIME_BITS  = crbg_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = crbg_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [1:0]            i_action,
    input  logic [TIME_BITS-1:0]  i_now,
    input  logic                  i_ok,
    input  crbg_pkg::t_cfg        i_cfg,
    output crbg_pkg::t_flags      o_flags,
    output logic [COUNT_BITS-1:0] o_count,
    output logic [TIME_BITS-1:0]  o_deadline
);

    localparam int EXP_W = (COUNT_BITS > 4) ? COUNT_BITS : 4;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [TIME_BITS-1:0]  r_deadline, n_deadline;
    logic                  r_link, n_link;
    logic                  r_opened, n_opened;

    logic [COUNT_BITS-1:0] fail_count;
    logic [COUNT_BITS-1:0] count_m1;
    logic [EXP_W-1:0]      exp_a, exp_b;
    logic [3:0]            exp_sel;
    logic [TIME_BITS-1:0]  wait_ms;
    logic [TIME_BITS-1:0]  fail_deadline;
    logic [TIME_BITS-1:0]  delta;
    logic                  suppressed;
    logic                  fail;
    crbg_pkg::t_flags      flags;

    // backoff after a failure: initial << min(count-1, max_exp)
    always_comb begin
        fail_count    = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;
        count_m1      = fail_count - 1'b1;
        exp_a         = EXP_W'(count_m1);
        exp_b         = EXP_W'(i_cfg.backoff_max_exponent);
        exp_sel       = (exp_a > exp_b) ? i_cfg.backoff_max_exponent : exp_a[3:0];
        wait_ms       = TIME_BITS'(i_cfg.backoff_initial_ms) << exp_sel;
        fail_deadline = i_now + wait_ms;
    end

    // wrapped distance to the deadline
    always_comb begin
        delta      = r_deadline - i_now;
        suppressed = (r_deadline != '0) && (i_now != '0)
                     && (delta < TIME_BITS'(i_cfg.suppression_window_ms));
    end

    always_comb begin
        n_count    = r_count;
        n_deadline = r_deadline;
        n_link     = r_link;
        n_opened   = r_opened;
        fail       = 1'b0;
        flags      = '0;
        case (i_action)
            crbg_pkg::ACT_ATTEMPT: begin
                if (r_link) begin
                    flags.may_connect = 1'b1;
                end else if (!suppressed) begin
                    flags.may_connect = 1'b1;
                    if (r_count != '0) begin
                        n_deadline       = i_now + TIME_BITS'(i_cfg.lock_hold_ms);
                        flags.lock_taken = 1'b1;
                    end
                end
            end
            crbg_pkg::ACT_OUTCOME: begin
                if (!r_link) begin
                    if (i_ok) begin
                        n_link   = 1'b1;
                        n_opened = 1'b1;
                        if (r_count != '0) begin
                            n_deadline = '0;
                        end
                    end else begin
                        fail = 1'b1;
                    end
                end
            end
            crbg_pkg::ACT_CLOSE: begin
                if (r_link) begin
                    n_link = 1'b0;
                    fail   = r_opened;
                end
            end
            crbg_pkg::ACT_END_REQ: begin
                if (r_opened && (r_count != '0) && r_link) begin
                    n_count    = '0;
                    n_deadline = '0;
                end
                n_opened = 1'b0;
            end
            default: begin
            end
        endcase
        if (fail) begin
            n_count    = fail_count;
            n_deadline = fail_deadline;
        end
        flags.link_up = n_link;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_deadline <= '0;
            r_link     <= 1'b0;
            r_opened   <= 1'b0;
        end else if (i_step) begin
            r_count    <= n_count;
            r_deadline <= n_deadline;
            r_link     <= n_link;
            r_opened   <= n_opened;
        end
    end

    assign o_flags    = flags;
    assign o_count    = n_count;
    assign o_deadline = n_deadline;

endmodule

### rtl/connect_retry_backoff_gate.sv
// Connection retry gate with truncated binary exponential backoff. Each request
// carries an event kind (attempt, attempt outcome, link close, end of request)
// and a millisecond timestamp, and yields exactly one result: whether the
// attempt may go ahead, whether it took the exclusive retry lock, the
// saturating failure count, the retry deadline (0 when none) and the link
// state. One request is taken every clock cycle while the output side does not
// stall; a request waits in the input register and its result is loaded into
// the result register once that register can take it (input register, then
// result register). The state update of the single compare, shift and add
// path is combinational, so consecutive events chain without gaps. The input
// register lets a new request in while a finished result still waits on the
// output side.
// Configuration writes are accepted every cycle and should be made while idle.
`include "connect_retry_backoff_gate_defines.svh"

module connect_retry_backoff_gate #(
    parameter int TIME_BITS  = crbg_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = crbg_pkg::COUNT_BITS_DEF,
    parameter int S_DATA_W   = ((TIME_BITS + 1 + 7) / 8) * 8,
    parameter int M_DATA_W   = ((TIME_BITS + COUNT_BITS + 3 + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // now_ms, connect_ok, zero fill
    input  logic [S_DATA_W-1:0]                s_axis_tdata,
    // action
    input  logic [1:0]                         s_axis_tuser,
    // master side
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // may_connect, lock_taken, failure_total, retry_after_ms, link_up, zero fill
    output logic [M_DATA_W-1:0]                m_axis_tdata,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [crbg_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [crbg_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int M_USED = TIME_BITS + COUNT_BITS + 3;

    crbg_pkg::t_cfg        r_cfg;
    logic                  r_in_valid;
    logic [1:0]            r_in_action;
    logic [TIME_BITS-1:0]  r_in_now;
    logic                  r_in_ok;
    logic                  r_out_valid;
    crbg_pkg::t_flags      r_out_flags;
    logic [COUNT_BITS-1:0] r_out_count;
    logic [TIME_BITS-1:0]  r_out_deadline;

    logic                  adv;
    crbg_pkg::t_flags      core_flags;
    logic [COUNT_BITS-1:0] core_count;
    logic [TIME_BITS-1:0]  core_deadline;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.backoff_initial_ms    <= crbg_pkg::INITIAL_RST;
            r_cfg.backoff_max_exponent  <= crbg_pkg::MAX_EXP_RST;
            r_cfg.lock_hold_ms          <= crbg_pkg::LOCK_HOLD_RST;
            r_cfg.suppression_window_ms <= crbg_pkg::WINDOW_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                crbg_pkg::CFG_INITIAL:   r_cfg.backoff_initial_ms    <= i_cfg_data[15:0];
                crbg_pkg::CFG_MAX_EXP:   r_cfg.backoff_max_exponent  <= i_cfg_data[3:0];
                crbg_pkg::CFG_LOCK_HOLD: r_cfg.lock_hold_ms          <= i_cfg_data[15:0];
                crbg_pkg::CFG_WINDOW:    r_cfg.suppression_window_ms <= i_cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    // the input register moves on whenever the result register can take it
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_action <= s_axis_tuser;
            r_in_now    <= s_axis_tdata[TIME_BITS-1:0];
            r_in_ok     <= s_axis_tdata[TIME_BITS];
        end
    end

    crbg_core #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (adv),
        .i_action   (r_in_action),
        .i_now      (r_in_now),
        .i_ok       (r_in_ok),
        .i_cfg      (r_cfg),
        .o_flags    (core_flags),
        .o_count    (core_count),
        .o_deadline (core_deadline)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_flags    <= core_flags;
            r_out_count    <= core_count;
            r_out_deadline <= core_deadline;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_DATA_W - M_USED){1'b0}}, r_out_flags.link_up, r_out_deadline,
                            r_out_count, r_out_flags.lock_taken, r_out_flags.may_connect};

    `CRBG_ASSERT_NOW(a_lock_needs_failures, i_clk, i_rst_n,
        r_out_valid && r_out_flags.lock_taken,
        r_out_flags.may_connect && (r_out_count != '0) && !r_out_flags.link_up,
        "lock taken without a pending failure or a granted attempt")
    `CRBG_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, adv, r_out_valid,
        "request left the input register but no result was posted")
    `CRBG_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, !s_axis_tready,
        r_in_valid && r_out_valid && !m_axis_tready,
        "input stalled while the pipeline had room")

endmodule
